// File: rtl/ffba_pkg.sv
// shared constants, codes and controller/datapath interface types for the block allocator
package ffba_pkg;

  localparam int HEAP_BYTES    = 1024;
  localparam int GRANULE_BYTES = 16;
  localparam int NUM_GRANULES  = HEAP_BYTES / GRANULE_BYTES;
  localparam int GW            = $clog2(NUM_GRANULES);
  localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);

  localparam int REQ_W    = 16;
  localparam int OFFSET_W = 10;
  localparam int NEED_W   = REQ_W + 1 - GRAN_SHIFT;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_FREE    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_COAL,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic load;
    logic alloc_step;
    logic free_step;
    logic coal_step;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic need_zero;
    logic alloc_done;
    logic coal_last;
  } dp_status_t;

endpackage

// File: rtl/ffba_ctrl.sv
// controller state machine sequencing allocate scan, free check and coalescing walk
module ffba_ctrl import ffba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       cmd_i,
  input  logic       out_ready_i,
  input  dp_status_t dp_status_i,
  output dp_cmd_t    dp_cmd_o,
  output logic       in_ready_o,
  output logic       out_valid_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (cmd_i == CMD_FREE) ? ST_FREE : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (dp_status_i.need_zero || dp_status_i.alloc_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_FREE: state_d = ST_COAL;
      ST_COAL: begin
        if (dp_status_i.coal_last) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        dp_cmd_o.load = in_valid_i;
      end
      ST_ALLOC: dp_cmd_o.alloc_step = !dp_status_i.need_zero;
      ST_FREE:  dp_cmd_o.free_step  = 1'b1;
      ST_COAL:  dp_cmd_o.coal_step  = 1'b1;
      ST_PUSH:  dp_cmd_o.push       = slot_free;
      default: begin
        dp_cmd_o   = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // output register: filled on push, emptied when the consumer takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/ffba_datapath.sv
// granule bitmaps, scan counters and result registers of the block allocator
module ffba_datapath import ffba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             dp_cmd_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic [OFFSET_W-1:0] free_offset_i,
  output dp_status_t          dp_status_o,
  output logic                status_o,
  output logic [OFFSET_W-1:0] payload_offset_o
);

  logic [NUM_GRANULES-1:0] start_q, start_d;
  logic [NUM_GRANULES-1:0] used_q, used_d;
  logic [GW:0]             g_q, g_d;
  logic [GW-1:0]           h_q, h_d;
  logic [GW:0]             len_q, len_d;
  logic [NEED_W-1:0]       need_q, need_d;
  logic                    prev_free_q, prev_free_d;
  logic [OFFSET_W-1:0]     off_q;
  logic                    rs_status_q, rs_status_d;
  logic [OFFSET_W-1:0]     rs_pay_q, rs_pay_d;
  logic                    out_status_q;
  logic [OFFSET_W-1:0]     out_pay_q;

  logic [GW-1:0]           gi;
  logic                    at_end, boundary, fit, room_split;
  logic [NEED_W-1:0]       len_ext;
  logic [GW-1:0]           split_idx;
  logic [GW:0]             hp1;
  logic [REQ_W:0]          req_rnd;
  logic [OFFSET_W-1:0]     hdr_gran;
  logic [GW-1:0]           free_h;
  logic                    free_hit;

  assign gi         = g_q[GW-1:0];
  assign at_end     = g_q[GW];
  assign boundary   = at_end || start_q[gi];
  assign len_ext    = {{(NEED_W-GW-1){1'b0}}, len_q};
  assign fit        = !used_q[h_q] && (len_ext >= need_q);
  assign room_split = {1'b0, len_ext} >= ({1'b0, need_q} + (NEED_W+1)'(2));
  assign split_idx  = h_q + need_q[GW-1:0] + GW'(1);
  assign hp1        = {1'b0, h_q} + (GW+1)'(1);
  assign req_rnd    = {1'b0, request_bytes_i} + (REQ_W+1)'(GRANULE_BYTES - 1);

  // header granule sits one granule below the payload offset
  assign hdr_gran = (off_q >> GRAN_SHIFT) - OFFSET_W'(1);
  assign free_h   = hdr_gran[GW-1:0];
  assign free_hit = (off_q >= OFFSET_W'(GRANULE_BYTES))
                 && (off_q[GRAN_SHIFT-1:0] == '0)
                 && (hdr_gran < OFFSET_W'(NUM_GRANULES))
                 && start_q[free_h];

  assign dp_status_o.need_zero  = (need_q == '0);
  assign dp_status_o.alloc_done = boundary && (fit || at_end);
  assign dp_status_o.coal_last  = (gi == {GW{1'b1}});

  always_comb begin
    start_d     = start_q;
    used_d      = used_q;
    g_d         = g_q;
    h_d         = h_q;
    len_d       = len_q;
    need_d      = need_q;
    prev_free_d = prev_free_q;
    rs_status_d = rs_status_q;
    rs_pay_d    = rs_pay_q;

    if (dp_cmd_i.load) begin
      g_d         = (GW+1)'(1);
      h_d         = '0;
      len_d       = '0;
      need_d      = req_rnd[REQ_W:GRAN_SHIFT];
      prev_free_d = 1'b0;
      rs_status_d = STATUS_FAIL;
      rs_pay_d    = '0;
    end

    // first-fit walk: a block is judged when the next header or the heap end is reached
    if (dp_cmd_i.alloc_step) begin
      if (boundary) begin
        if (fit) begin
          used_d[h_q] = 1'b1;
          if (room_split) begin
            start_d[split_idx] = 1'b1;
            used_d[split_idx]  = 1'b0;
          end
          rs_status_d = STATUS_OK;
          rs_pay_d    = OFFSET_W'({hp1, GRAN_SHIFT'(0)});
        end else begin
          h_d   = gi;
          len_d = '0;
          g_d   = g_q + (GW+1)'(1);
        end
      end else begin
        len_d = len_q + (GW+1)'(1);
        g_d   = g_q + (GW+1)'(1);
      end
    end

    if (dp_cmd_i.free_step) begin
      if (free_hit) begin
        used_d[free_h] = 1'b0;
        rs_status_d    = STATUS_OK;
      end
      g_d = '0;
    end

    // merge walk, granule zero only seeds the previous-free flag
    if (dp_cmd_i.coal_step) begin
      if (gi == '0) begin
        prev_free_d = !used_q[0];
      end else if (start_q[gi]) begin
        if (prev_free_q && !used_q[gi]) begin
          start_d[gi] = 1'b0;
          used_d[gi]  = 1'b0;
        end else begin
          prev_free_d = !used_q[gi];
        end
      end
      g_d = g_q + (GW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= {{(NUM_GRANULES-1){1'b0}}, 1'b1};
      used_q  <= '0;
    end else begin
      start_q <= start_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q         <= g_d;
    h_q         <= h_d;
    len_q       <= len_d;
    need_q      <= need_d;
    prev_free_q <= prev_free_d;
    rs_status_q <= rs_status_d;
    rs_pay_q    <= rs_pay_d;
    if (dp_cmd_i.load) begin
      off_q <= free_offset_i;
    end
    if (dp_cmd_i.push) begin
      out_status_q <= rs_status_q;
      out_pay_q    <= rs_pay_q;
    end
  end

  assign status_o         = out_status_q;
  assign payload_offset_o = out_pay_q;

`ifndef SYNTHESIS
  a_heap_start: assert property (@(posedge clk_i) disable iff (!rst_ni) start_q[0])
    else $error("granule zero lost its block header");
  a_used_is_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q & ~start_q) == '0)
    else $error("used mark on a granule that is not a block header");
  a_alloc_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.alloc_step && boundary && fit |=> rs_status_q == STATUS_OK && rs_pay_q != '0)
    else $error("successful allocate without a payload offset");
`endif

endmodule

// File: rtl/first_fit_block_allocator_core.sv
// top level of the first-fit block allocator with coalescing
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o    cmd_i, request_bytes_i, free_offset_i
//  out      output     out_valid_o / out_ready_i  status_o, payload_offset_o
//
// allocate: one granule of the first-fit scan per cycle
// free: one header check then a merge walk over all 64 granules
// one transaction is in work at a time; the result is then pushed to the output register
// a new transaction is taken while the previous result still waits to be taken
// reset puts the heap back to one free block at once
module first_fit_block_allocator_core import ffba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic [OFFSET_W-1:0] free_offset_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                status_o,
  output logic [OFFSET_W-1:0] payload_offset_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .out_ready_i (out_ready_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  ffba_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dp_cmd_i         (dp_cmd),
    .request_bytes_i  (request_bytes_i),
    .free_offset_i    (free_offset_i),
    .dp_status_o      (dp_status),
    .status_o         (status_o),
    .payload_offset_o (payload_offset_o)
  );

endmodule

// File: bench/first_fit_block_allocator_core_tb.sv
// testbench for the first-fit block allocator: directed and random traffic checked by a heap model
`timescale 1ns / 1ps

module first_fit_block_allocator_core_tb;
  import ffba_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int END_WAIT   = 100;

  typedef struct packed {
    logic                status;
    logic [OFFSET_W-1:0] offset;
  } heap_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic                cmd_i           = CMD_ALLOC;
  logic [REQ_W-1:0]    request_bytes_i = '0;
  logic [OFFSET_W-1:0] free_offset_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic                status_o;
  logic [OFFSET_W-1:0] payload_offset_o;

  first_fit_block_allocator_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .request_bytes_i  (request_bytes_i),
    .free_offset_i    (free_offset_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .payload_offset_o (payload_offset_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // heap model: header granules and headers of used blocks
  logic [NUM_GRANULES-1:0] hdr_map  = 64'h1;
  logic [NUM_GRANULES-1:0] busy_map = '0;

  heap_result_t        pending_results[$];
  logic [OFFSET_W-1:0] live_offsets[$];

  int errors       = 0;
  int n_checked    = 0;
  int n_alloc_ok   = 0;
  int n_alloc_fail = 0;
  int n_free_ok    = 0;
  int n_free_miss  = 0;
  int idle_cycles  = 0;
  int stall_left   = 0;
  bit gaps_off     = 1'b0;
  bit stall_off    = 1'b0;

  function automatic int unsigned block_limit(int unsigned h);
    int unsigned g;
    g = h + 1;
    while (g < NUM_GRANULES && !hdr_map[g]) g++;
    return g;
  endfunction

  task automatic heap_allocate(input logic [REQ_W-1:0] req, output heap_result_t r);
    int unsigned need;
    int unsigned h;
    int unsigned e;
    int unsigned avail;
    r.status = STATUS_FAIL;
    r.offset = '0;
    if (req != 0) begin
      need = (int'(req) + GRANULE_BYTES - 1) / GRANULE_BYTES;
      h = 0;
      while (h < NUM_GRANULES) begin
        e = block_limit(h);
        avail = e - h - 1;
        if (!busy_map[h] && avail >= need) begin
          // remainder keeps its own header only if a payload granule is left
          if (avail >= need + 2) begin
            hdr_map[h + 1 + need]  = 1'b1;
            busy_map[h + 1 + need] = 1'b0;
          end
          busy_map[h] = 1'b1;
          r.status = STATUS_OK;
          r.offset = OFFSET_W'((h + 1) * GRANULE_BYTES);
          break;
        end
        h = e;
      end
    end
  endtask

  task automatic heap_release(input logic [OFFSET_W-1:0] off, output heap_result_t r);
    int unsigned h;
    bit prev_free;
    r.status = STATUS_FAIL;
    r.offset = '0;
    if (off >= GRANULE_BYTES && (off % GRANULE_BYTES) == 0) begin
      h = off / GRANULE_BYTES - 1;
      if (h < NUM_GRANULES && hdr_map[h]) begin
        busy_map[h] = 1'b0;
        r.status = STATUS_OK;
      end
    end
    // merge pass runs even after a miss
    prev_free = !busy_map[0];
    for (int unsigned g = 1; g < NUM_GRANULES; g++) begin
      if (!hdr_map[g]) continue;
      if (prev_free && !busy_map[g]) begin
        hdr_map[g]  = 1'b0;
        busy_map[g] = 1'b0;
      end else begin
        prev_free = !busy_map[g];
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // entered and left at a falling edge; valid stays up if the next transaction follows at once
  task automatic send_request(input logic c, input logic [REQ_W-1:0] req,
                              input logic [OFFSET_W-1:0] off);
    int gap;
    heap_result_t r;
    gap = gaps_off ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= c;
    request_bytes_i <= req;
    free_offset_i   <= off;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (c == CMD_ALLOC) begin
      heap_allocate(req, r);
      if (r.status == STATUS_OK) begin
        n_alloc_ok++;
        live_offsets.push_back(r.offset);
      end else begin
        n_alloc_fail++;
      end
    end else begin
      heap_release(off, r);
      if (r.status == STATUS_OK) begin
        n_free_ok++;
        for (int i = live_offsets.size() - 1; i >= 0; i--)
          if (live_offsets[i] == off) live_offsets.delete(i);
      end else begin
        n_free_miss++;
      end
    end
    pending_results.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic alloc_bytes(input logic [REQ_W-1:0] req);
    send_request(CMD_ALLOC, req, OFFSET_W'($urandom));
  endtask

  task automatic free_at(input logic [OFFSET_W-1:0] off);
    send_request(CMD_FREE, REQ_W'($urandom), off);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (status %0b offset %0d)",
                                  status_o, payload_offset_o));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0b, wanted %0b", status_o, want.status));
        if (payload_offset_o !== want.offset)
          report_mismatch($sformatf("payload offset %0d, wanted %0d",
                                    payload_offset_o, want.offset));
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (!stall_off && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic test_fresh_heap();
    alloc_bytes(16'd1008);      // whole heap in one block
    alloc_bytes(16'd1);         // nothing left
    free_at(10'd16);
    alloc_bytes(16'd1009);      // one byte too many
    alloc_bytes(16'd0);
    alloc_bytes(16'hFFFF);
    wait_drained();
  endtask

  task automatic test_free_misses();
    alloc_bytes(16'd16);
    alloc_bytes(16'd1);
    free_at(10'd0);
    free_at(10'd24);            // not on a granule
    free_at(10'd32);            // inside a payload, not a header
    free_at(10'h3FF);
    free_at(10'd16);
    free_at(10'd16);            // already free, still a match
    alloc_bytes(16'd17);        // skips the one-granule hole
    free_at(10'd48);
    free_at(10'd80);
    alloc_bytes(16'd1008);      // only fits if all merged back
    free_at(10'd16);
    wait_drained();
  endtask

  task automatic test_split_edges();
    alloc_bytes(16'd1000);      // exact fit
    free_at(10'd16);
    alloc_bytes(16'd992);       // one spare granule, too small to split
    free_at(10'd16);
    alloc_bytes(16'd976);       // just enough for a remainder block
    alloc_bytes(16'd16);        // lands at the top granule
    free_at(10'd16);
    free_at(10'd1008);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count);
    int r;
    int idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (live_offsets.size() == 0 || r < 45) begin
        r = $urandom_range(0, 99);
        if (r < 60)      alloc_bytes(REQ_W'($urandom_range(1, 128)));
        else if (r < 80) alloc_bytes(REQ_W'($urandom_range(129, 512)));
        else if (r < 90) alloc_bytes(REQ_W'($urandom_range(513, 1008)));
        else if (r < 93) alloc_bytes(16'd0);
        else if (r < 97) alloc_bytes(REQ_W'($urandom_range(1009, 65535)));
        else             alloc_bytes(REQ_W'($urandom));
      end else if (r < 85) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        free_at(live_offsets[idx]);
      end else if (r < 92) begin
        free_at(OFFSET_W'($urandom_range(0, NUM_GRANULES - 1) * GRANULE_BYTES));
      end else begin
        free_at(OFFSET_W'($urandom));
      end
    end
  endtask

  task automatic test_release_all();
    int idx;
    while (live_offsets.size() != 0) begin
      idx = $urandom_range(0, live_offsets.size() - 1);
      free_at(live_offsets[idx]);
    end
    alloc_bytes(16'd1008);
    free_at(10'd16);
  endtask

  task automatic test_back_to_back();
    gaps_off  = 1'b1;
    stall_off = 1'b1;
    test_random_traffic(200);
    gaps_off  = 1'b0;
    stall_off = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_fresh_heap();
    test_free_misses();
    test_split_edges();
    test_random_traffic(300);
    test_release_all();
    // hold the sender until every result is back
    wait_drained();
    test_random_traffic(250);
    test_back_to_back();
    test_release_all();
    test_random_traffic(450);
    test_release_all();

    wait_drained();
    repeat (END_WAIT) @(negedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d allocations (%0d granted, %0d refused), %0d frees (%0d hit, %0d missed)",
             n_alloc_ok + n_alloc_fail, n_alloc_ok, n_alloc_fail,
             n_free_ok + n_free_miss, n_free_ok, n_free_miss);
    $display("%0d results compared, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
